FILE: src/dtf_pkg.sv
// Shared types and constants of the decimal text to fixed-point parser.
// Holds the character codes, the controller/datapath command and status
// structs, and the power-of-ten table. Depends on nothing.
package dtf_pkg;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharPoint = 8'h2E;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharLf    = 8'h0A;

  localparam int unsigned IntW      = 31;
  localparam int unsigned FracAccW  = 20;
  localparam int unsigned ValueW    = 48;
  localparam int unsigned CountW    = 8;
  localparam logic [IntW-1:0] IntMax = '1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic set_neg;
    logic add_int;
    logic add_frac;
    logic count;
    logic start_div;
    logic div_step;
    logic load_out;
  } dtf_cmd_t;

  // Character class of the current input beat.
  typedef struct packed {
    logic is_digit;
    logic is_space;
    logic is_minus;
    logic is_plus;
    logic is_point;
  } dtf_status_t;

  // Divisor for the fraction scaling, 10 to the number of fraction digits.
  function automatic logic [FracAccW-1:0] pow10(input logic [2:0] digits);
    logic [FracAccW-1:0] result;
    case (digits)
      3'd0:    result = 20'd1;
      3'd1:    result = 20'd10;
      3'd2:    result = 20'd100;
      3'd3:    result = 20'd1000;
      3'd4:    result = 20'd10000;
      3'd5:    result = 20'd100000;
      default: result = 20'd1000000;
    endcase
    return result;
  endfunction

endpackage

FILE: src/decimal_text_to_fixed_parser.sv
// Top level of the ASCII decimal text to signed fixed-point parser.
// Joins the dtf_ctrl state machine and the dtf_datapath. Depends on dtf_pkg.
//
// The slave channel takes one character per beat: s_axis_tdata holds the
// character and s_axis_tuser marks the first character of a new number. A
// first beat drops any unfinished parse. Leading space, tab, CR and LF are
// skipped, then one optional sign, integer digits and an optional point with
// fraction digits are taken. The first character that fits none of these is
// the terminator; it is accepted but not counted, and it produces one beat on
// the master channel: the signed Q31.16 value (by default) with the count of
// consumed characters in m_axis_tdata, and the integer clamp flag in
// m_axis_tuser. Characters after the terminator are taken and ignored until
// the next first beat.
// Text streams in at one beat per cycle while s_axis_tready is high. After the
// terminator the fraction scaling runs through a restoring divider at one
// quotient bit per cycle: s_axis_tready stays low while it runs and until the
// result moves into the output register, and m_axis_tvalid rises with that
// load, which waits for the output register to be free. If the receiver stalls,
// the result waits in the output register while the next number streams in;
// a second result then waits for that register to empty. Reset leaves the
// block idle, waiting for a first beat, with no result pending.
module decimal_text_to_fixed_parser import dtf_pkg::*; #(
  parameter int unsigned MAX_FRAC_DIGITS = 6,
  parameter int unsigned FRAC_BITS       = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] ch
  input  logic        s_axis_tuser,   // [0] first
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [47:0] value_q16, [55:48] consumed
  output logic        m_axis_tuser    // [0] saturated
);

  dtf_cmd_t          cmd;
  dtf_status_t       status;
  logic [ValueW-1:0] value;
  logic [CountW-1:0] consumed;
  logic              saturated;

  dtf_ctrl #(
    .FRAC_BITS(FRAC_BITS)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_valid_i(s_axis_tvalid),
    .first_i  (s_axis_tuser),
    .m_ready_i(m_axis_tready),
    .status_i (status),
    .cmd_o    (cmd),
    .s_ready_o(s_axis_tready),
    .m_valid_o(m_axis_tvalid)
  );

  dtf_datapath #(
    .MAX_FRAC_DIGITS(MAX_FRAC_DIGITS),
    .FRAC_BITS      (FRAC_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ch_i       (s_axis_tdata),
    .cmd_i      (cmd),
    .status_o   (status),
    .value_o    (value),
    .consumed_o (consumed),
    .saturated_o(saturated)
  );

  assign m_axis_tdata = {consumed, value};
  assign m_axis_tuser = saturated;

endmodule

FILE: src/dtf_ctrl.sv
// Parse and sequencing state machine of the decimal text parser.
// Issues dtf_cmd_t commands to dtf_datapath from the character class it
// reports. Depends on dtf_pkg.
module dtf_ctrl import dtf_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  input  logic        first_i,
  input  logic        m_ready_i,
  input  dtf_status_t status_i,
  output dtf_cmd_t    cmd_o,
  output logic        s_ready_o,
  output logic        m_valid_o
);

  localparam int unsigned StepW = $clog2(FRAC_BITS);

  typedef enum logic [2:0] {
    ST_DONE,
    ST_LEAD,
    ST_INT,
    ST_FRAC,
    ST_DIV,
    ST_LOAD
  } state_e;

  state_e           state_q, state_d, phase;
  logic [StepW-1:0] step_q, step_d;
  logic             out_valid_q, out_valid_d;
  logic             accept, terminate;
  dtf_cmd_t         cmd;

  assign s_ready_o = (state_q != ST_DIV) && (state_q != ST_LOAD);
  assign accept    = s_valid_i && s_ready_o;
  assign m_valid_o = out_valid_q;
  assign cmd_o     = cmd;

  always_comb begin
    cmd         = '0;
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    terminate   = 1'b0;
    phase       = state_q;

    if (out_valid_q && m_ready_i) begin
      out_valid_d = 1'b0;
    end

    // A first character drops any unfinished parse and starts over.
    if (accept && first_i) begin
      cmd.clear = 1'b1;
      phase     = ST_LEAD;
    end

    if (accept) begin
      state_d = phase;
      unique case (phase)
        ST_LEAD: begin
          if (status_i.is_space) begin
            cmd.count = 1'b1;
          end else if (status_i.is_minus) begin
            cmd.set_neg = 1'b1;
            cmd.count   = 1'b1;
            state_d     = ST_INT;
          end else if (status_i.is_plus) begin
            cmd.count = 1'b1;
            state_d   = ST_INT;
          end else if (status_i.is_digit) begin
            cmd.add_int = 1'b1;
            cmd.count   = 1'b1;
            state_d     = ST_INT;
          end else if (status_i.is_point) begin
            cmd.count = 1'b1;
            state_d   = ST_FRAC;
          end else begin
            terminate = 1'b1;
          end
        end
        ST_INT: begin
          if (status_i.is_digit) begin
            cmd.add_int = 1'b1;
            cmd.count   = 1'b1;
          end else if (status_i.is_point) begin
            cmd.count = 1'b1;
            state_d   = ST_FRAC;
          end else begin
            terminate = 1'b1;
          end
        end
        ST_FRAC: begin
          if (status_i.is_digit) begin
            cmd.add_frac = 1'b1;
            cmd.count    = 1'b1;
          end else begin
            terminate = 1'b1;
          end
        end
        default: ;
      endcase
    end

    if (terminate) begin
      cmd.start_div = 1'b1;
      step_d        = StepW'(FRAC_BITS - 1);
      state_d       = ST_DIV;
    end

    unique case (state_q)
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (step_q == '0) begin
          state_d = ST_LOAD;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      ST_LOAD: begin
        // Wait here while the previous result still sits in the output.
        if (!out_valid_q || m_ready_i) begin
          cmd.load_out = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_DONE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_DONE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: src/dtf_datapath.sv
// Accumulators, fraction divider and output register of the decimal parser.
// Acts on dtf_cmd_t commands and reports the class of each character.
// Depends on dtf_pkg.
module dtf_datapath import dtf_pkg::*; #(
  parameter int unsigned MAX_FRAC_DIGITS = 6,
  parameter int unsigned FRAC_BITS       = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        ch_i,
  input  dtf_cmd_t          cmd_i,
  output dtf_status_t       status_o,
  output logic [ValueW-1:0] value_o,
  output logic [CountW-1:0] consumed_o,
  output logic              saturated_o
);

  logic                 neg_q, neg_d;
  logic [IntW-1:0]      int_q, int_d;
  logic [FracAccW-1:0]  frac_q, frac_d;
  logic [2:0]           fdig_q, fdig_d;
  logic [CountW-1:0]    cnt_q, cnt_d;
  logic                 clamp_q, clamp_d;

  logic                 base_neg, base_clamp;
  logic [IntW-1:0]      base_int;
  logic [FracAccW-1:0]  base_frac;
  logic [2:0]           base_fdig;
  logic [CountW-1:0]    base_cnt;
  logic [3:0]           digit;
  logic [35:0]          int_wide;

  logic [FracAccW-1:0]  rem_q, divisor_q;
  logic [FRAC_BITS-1:0] quot_q;
  logic [FracAccW:0]    trial;
  logic                 trial_ge;
  logic [ValueW-1:0]    mag;

  logic [ValueW-1:0]    value_q;
  logic [CountW-1:0]    consumed_q;
  logic                 saturated_q;

  assign status_o.is_digit = (ch_i >= CharZero) && (ch_i <= CharNine);
  assign status_o.is_space = (ch_i == CharSpace) || (ch_i == CharTab) ||
                             (ch_i == CharCr) || (ch_i == CharLf);
  assign status_o.is_minus = (ch_i == CharMinus);
  assign status_o.is_plus  = (ch_i == CharPlus);
  assign status_o.is_point = (ch_i == CharPoint);

  assign digit = status_o.is_digit ? 4'(ch_i - CharZero) : 4'd0;

  always_comb begin
    base_neg   = cmd_i.clear ? 1'b0 : neg_q;
    base_int   = cmd_i.clear ? '0 : int_q;
    base_frac  = cmd_i.clear ? '0 : frac_q;
    base_fdig  = cmd_i.clear ? '0 : fdig_q;
    base_cnt   = cmd_i.clear ? '0 : cnt_q;
    base_clamp = cmd_i.clear ? 1'b0 : clamp_q;

    neg_d   = base_neg | cmd_i.set_neg;
    int_d   = base_int;
    frac_d  = base_frac;
    fdig_d  = base_fdig;
    cnt_d   = base_cnt;
    clamp_d = base_clamp;

    int_wide = 36'(base_int) * 36'd10 + 36'(digit);
    if (cmd_i.add_int) begin
      if (int_wide > 36'(IntMax)) begin
        int_d   = IntMax;
        clamp_d = 1'b1;
      end else begin
        int_d = IntW'(int_wide);
      end
    end

    // Digits past the fraction limit are consumed and counted but leave the fraction alone.
    if (cmd_i.add_frac && (base_fdig < 3'(MAX_FRAC_DIGITS))) begin
      frac_d = base_frac * FracAccW'(10) + FracAccW'(digit);
      fdig_d = base_fdig + 3'd1;
    end

    if (cmd_i.count && (base_cnt != '1)) begin
      cnt_d = base_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neg_q   <= 1'b0;
      int_q   <= '0;
      frac_q  <= '0;
      fdig_q  <= '0;
      cnt_q   <= '0;
      clamp_q <= 1'b0;
    end else begin
      neg_q   <= neg_d;
      int_q   <= int_d;
      frac_q  <= frac_d;
      fdig_q  <= fdig_d;
      cnt_q   <= cnt_d;
      clamp_q <= clamp_d;
    end
  end

  // Restoring division of frac * 2^FRAC_BITS by 10^digits, one quotient bit
  // per step. The remainder stays below the divisor, so the quotient fits in
  // FRAC_BITS bits. The divider loads the fraction as seen after a possible
  // clear, so a terminator that also starts a new string divides zero.
  assign trial    = {rem_q, 1'b0};
  assign trial_ge = trial >= {1'b0, divisor_q};

  assign mag = ValueW'({int_q, quot_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_div) begin
      rem_q     <= base_frac;
      divisor_q <= pow10(base_fdig);
      quot_q    <= '0;
    end else if (cmd_i.div_step) begin
      rem_q  <= trial_ge ? FracAccW'(trial - {1'b0, divisor_q}) : FracAccW'(trial);
      quot_q <= {quot_q[FRAC_BITS-2:0], trial_ge};
    end
    if (cmd_i.load_out) begin
      value_q     <= neg_q ? (ValueW'(0) - mag) : mag;
      consumed_q  <= cnt_q;
      saturated_q <= clamp_q;
    end
  end

  assign value_o     = value_q;
  assign consumed_o  = consumed_q;
  assign saturated_o = saturated_q;

endmodule

FILE: src/dtf_checker.sv
// Port-level checks for decimal_text_to_fixed_parser, bound to the top level.
// Sees only the top-level ports. Depends on nothing else.
module dtf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // A stalled result holds its beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result beat changed");

  // The block only goes busy on an accepted terminator beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready) |-> $past(s_axis_tvalid))
    else $error("input went busy without an accepted beat");

  // The fraction scaling keeps the input busy; a busy period must not be cut short.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready) |-> ##1 !s_axis_tready ##1 !s_axis_tready)
    else $error("busy period too short");

  // A new result only appears at the end of a busy period.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared outside a busy period");

  // Nothing consumed means a zero value and no clamp.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[55:48] == 8'd0) |->
      (m_axis_tdata[47:0] == 48'd0) && !m_axis_tuser)
    else $error("nonzero value with nothing consumed");

endmodule

bind decimal_text_to_fixed_parser dtf_checker u_dtf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

FILE: tb/tb_decimal_text_to_fixed_parser.sv
`timescale 1ns / 100ps
// Self-checking testbench of decimal_text_to_fixed_parser: streams of number text
// with random handshake gaps, checked beat by beat against a built-in parse predictor.
// Depends on dtf_pkg and the parser RTL.

localparam int unsigned MaxFracDigits = 6;
localparam int unsigned FracBits      = 16;
localparam logic [63:0] IntClamp      = 64'd2147483647;

// One expected result beat of the parser.
typedef struct packed {
  logic [47:0] value;
  logic [7:0]  consumed;
  logic        saturated;
} parse_result_t;

// Parse phases of the predictor; codes above PhFrac behave as PhDone.
typedef enum logic [2:0] {
  PhDone = 3'd0,
  PhLead = 3'd1,
  PhInt  = 3'd2,
  PhFrac = 3'd3
} parse_phase_e;

// Tracks the parse state of the text stream and holds the values still owed by the block.
class parse_scoreboard;
  parse_phase_e  phase;
  bit            negative;
  bit [31:0]     int_acc;
  bit [19:0]     frac_acc;
  bit [2:0]      frac_digits;
  bit [7:0]      char_count;
  bit            clamp_flag;
  parse_result_t expected_q[$];
  int unsigned   mismatches;
  int unsigned   results_seen;
  int unsigned   clamped_seen;
  int unsigned   negative_seen;
  int unsigned   full_count_seen;

  function new();
    phase           = PhDone;
    mismatches      = 0;
    results_seen    = 0;
    clamped_seen    = 0;
    negative_seen   = 0;
    full_count_seen = 0;
    clear_parse();
  endfunction

  function void clear_parse();
    negative    = 1'b0;
    int_acc     = '0;
    frac_acc    = '0;
    frac_digits = '0;
    char_count  = '0;
    clamp_flag  = 1'b0;
  endfunction

  function void bump_count();
    if (char_count != 8'hFF) char_count++;
  endfunction

  function void add_int_digit(bit [3:0] digit);
    bit [63:0] grown;
    grown = 64'(int_acc) * 64'd10 + 64'(digit);
    if (grown > IntClamp) begin
      grown      = IntClamp;
      clamp_flag = 1'b1;
    end
    int_acc = grown[31:0];
  endfunction

  // The terminator: scale the fraction, apply the sign and queue the result.
  function void close_number();
    bit [63:0]     divisor;
    bit [63:0]     magnitude;
    bit [63:0]     signed_val;
    parse_result_t res;
    divisor = 64'd1;
    repeat (frac_digits) divisor = divisor * 64'd10;
    magnitude  = (64'(int_acc) << FracBits) + ((64'(frac_acc) << FracBits) / divisor);
    signed_val = negative ? (64'd0 - magnitude) : magnitude;
    res.value     = signed_val[47:0];
    res.consumed  = char_count;
    res.saturated = clamp_flag;
    expected_q = {expected_q, res};
    phase = PhDone;
  endfunction

  // Advances the parse by one accepted character beat.
  function void take_char(logic [7:0] ch, logic first);
    bit is_digit;
    bit is_space;
    is_digit = (ch >= dtf_pkg::CharZero) && (ch <= dtf_pkg::CharNine);
    is_space = ch inside {dtf_pkg::CharSpace, dtf_pkg::CharTab, dtf_pkg::CharCr,
                          dtf_pkg::CharLf};
    if (first) begin
      clear_parse();
      phase = PhLead;
    end
    case (phase)
      PhLead: begin
        if (is_space) begin
          bump_count();
        end else if (ch == dtf_pkg::CharMinus) begin
          negative = 1'b1;
          bump_count();
          phase = PhInt;
        end else if (ch == dtf_pkg::CharPlus) begin
          bump_count();
          phase = PhInt;
        end else if (is_digit) begin
          add_int_digit(ch[3:0]);
          bump_count();
          phase = PhInt;
        end else if (ch == dtf_pkg::CharPoint) begin
          bump_count();
          phase = PhFrac;
        end else begin
          close_number();
        end
      end
      PhInt: begin
        if (is_digit) begin
          add_int_digit(ch[3:0]);
          bump_count();
        end else if (ch == dtf_pkg::CharPoint) begin
          bump_count();
          phase = PhFrac;
        end else begin
          close_number();
        end
      end
      PhFrac: begin
        if (is_digit) begin
          // Digits past the sixth are counted but leave the fraction alone.
          if (frac_digits < MaxFracDigits) begin
            frac_acc = 20'(32'(frac_acc) * 32'd10 + 32'(ch[3:0]));
            frac_digits++;
          end
          bump_count();
        end else begin
          close_number();
        end
      end
      default: ;
    endcase
  endfunction

  function void compare_beat(logic [47:0] value, logic [7:0] consumed, logic saturated);
    parse_result_t exp_r;
    if (expected_q.size() == 0) begin
      $error("Result beat with no number pending: value_q16 %0d, consumed %0d",
             $signed(value), consumed);
      mismatches++;
      return;
    end
    exp_r = expected_q.pop_front();
    results_seen++;
    if (exp_r.saturated) clamped_seen++;
    if (exp_r.value[47]) negative_seen++;
    if (exp_r.consumed == 8'hFF) full_count_seen++;
    if (value !== exp_r.value) begin
      $error("value_q16 mismatch: expected %0d, actual %0d",
             $signed(exp_r.value), $signed(value));
      mismatches++;
    end
    if (consumed !== exp_r.consumed) begin
      $error("consumed mismatch: expected %0d, actual %0d", exp_r.consumed, consumed);
      mismatches++;
    end
    if (saturated !== exp_r.saturated) begin
      $error("saturated mismatch: expected %0d, actual %0d", exp_r.saturated, saturated);
      mismatches++;
    end
  endfunction
endclass

module tb_decimal_text_to_fixed_parser;
  import dtf_pkg::*;

  // Stimulus stops once this many characters of number text have been sent.
  localparam int unsigned ItemTarget     = 1600;
  // Length of the deliberate receiver stall that backs the block up.
  localparam int unsigned SinkHoldCycles = 400;
  // Extra wait at the end of the run, a little longer than the fraction scaling.
  localparam int unsigned DrainCycles    = FracBits + 8;
  // Cycles without any accepted beat before the run is declared hung.
  localparam int unsigned StallLimit     = 3000;

  typedef logic [7:0] text_t[$];

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tuser;

  // Random gaps on each side can be switched off for a quiet stretch.
  bit          src_idle_on   = 1'b1;
  bit          sink_idle_on  = 1'b1;
  // Set by the stimulus, cleared by the receiver once its long stall has run out.
  bit          hold_off_req  = 1'b0;
  int unsigned chars_sent    = 0;
  int unsigned numbers_sent  = 0;
  int unsigned stall_cycles  = 0;

  parse_scoreboard parses = new();

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  decimal_text_to_fixed_parser #(
    .MAX_FRAC_DIGITS(MaxFracDigits),
    .FRAC_BITS      (FracBits)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // [7:0] ch
    .s_axis_tuser (s_axis_tuser),   // [0] first
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // [47:0] value_q16, [55:48] consumed
    .m_axis_tuser (m_axis_tuser)    // [0] saturated
  );

  // Every result beat taken at a rising edge is checked against the oldest expected value.
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      parses.compare_beat(m_axis_tdata[47:0], m_axis_tdata[55:48], m_axis_tuser);
    end
  end

  // Watchdog: the run is hung when neither side moves a beat for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Receiver: ready changes on falling edges. On request it holds off for a long stretch,
  // so results pile up and the block has to stop taking characters.
  initial begin : result_sink
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (SinkHoldCycles) @(negedge clk_i);
        hold_off_req = 1'b0;
      end
      m_axis_tready <= !(sink_idle_on && ($urandom_range(99) < 8));
    end
  end

  // Offers one character beat and returns on the falling edge after it was taken.
  // Must be entered on a falling edge.
  task automatic send_char(input logic [7:0] ch, input logic first);
    while (src_idle_on && ($urandom_range(99) < 8)) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tuser  <= first;
    do @(posedge clk_i); while (!s_axis_tready);
    parses.take_char(ch, first);
    @(negedge clk_i);
  endtask

  // Sends a whole string; its first character carries the first flag.
  task automatic send_text(input text_t txt);
    foreach (txt[i]) send_char(txt[i], i == 0);
    chars_sent += txt.size();
    numbers_sent++;
  endtask

  // Stops offering and waits until the block has delivered every result it owes.
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (parses.expected_q.size() != 0);
  endtask

  function automatic logic [7:0] rand_digit();
    return 8'(CharZero + $urandom_range(9));
  endfunction

  function automatic logic [7:0] rand_space();
    case ($urandom_range(3))
      0:       return CharSpace;
      1:       return CharTab;
      2:       return CharCr;
      default: return CharLf;
    endcase
  endfunction

  // A well-formed number: optional whitespace, optional sign, integer digits, optional
  // point with fraction digits, then a character that ends the parse in any phase.
  // A long run carries more than 255 fraction digits so the count saturates.
  function automatic text_t make_number(input bit long_run);
    text_t       txt;
    string       edge_digits;
    logic [7:0]  term;
    int unsigned shape;
    edge_digits = "214748364";
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 3)) txt = {txt, rand_space()};
    end
    case ($urandom_range(2))
      1:       txt = {txt, CharPlus};
      2:       txt = {txt, CharMinus};
      default: ;
    endcase
    shape = $urandom_range(9);
    if (shape == 0) begin
      // Long integers, most of them past the clamp.
      txt = {txt, 8'(CharZero + $urandom_range(1, 9))};
      repeat ($urandom_range(9, 12)) txt = {txt, rand_digit()};
    end else if (shape == 1) begin
      // Right at the clamp limit.
      foreach (edge_digits[i]) txt = {txt, 8'(edge_digits[i])};
      txt = {txt, 8'(CharZero + $urandom_range(6, 9))};
    end else begin
      repeat ($urandom_range(0, 6)) txt = {txt, rand_digit()};
    end
    if (long_run) begin
      txt = {txt, CharPoint};
      repeat ($urandom_range(256, 270)) txt = {txt, rand_digit()};
    end else if ($urandom_range(9) < 6) begin
      txt = {txt, CharPoint};
      repeat ($urandom_range(0, 8)) txt = {txt, rand_digit()};
    end
    if ($urandom_range(3) == 0) begin
      term = 8'h00;
    end else begin
      do term = 8'($urandom_range(255));
      while (((term >= CharZero) && (term <= CharNine)) ||
             (term inside {CharPoint, CharPlus, CharMinus, CharSpace, CharTab, CharCr, CharLf}));
    end
    txt = {txt, term};
    return txt;
  endfunction

  initial begin : stimulus
    text_t       txt;
    int unsigned long_at;
    int unsigned pick;

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part.
    // While idle after reset, a character without the first flag is dropped.
    send_char("7", 1'b0);
    // An unfinished number is dropped when the next first beat arrives.
    send_char("8", 1'b1);
    // A lone minus sign ended by whitespace gives a plain zero.
    txt = '{CharMinus, CharSpace};
    send_text(txt);
    // All whitespace kinds, a bare point, one fraction digit too many, top byte value.
    txt = '{CharSpace, CharTab, CharCr, CharLf, CharPoint,
            "1", "2", "3", "4", "5", "6", "7", 8'hFF};
    send_text(txt);
    // Plus sign and an integer past the clamp, ended by the string terminator byte.
    txt = '{CharPlus, "4", "2", "9", "4", "9", "6", "7", "2", "9", "6", 8'h00};
    send_text(txt);
    wait_for_results();

    // Random part: mostly well-formed numbers, some cut short, some plain noise.
    long_at = $urandom_range(20, 80);
    while (chars_sent < ItemTarget) begin
      if (numbers_sent == 30) hold_off_req = 1'b1;
      if (numbers_sent == 120) wait_for_results();
      src_idle_on  = !(numbers_sent inside {[60:100]});
      sink_idle_on = src_idle_on;
      pick = $urandom_range(99);
      txt  = make_number(numbers_sent == long_at);
      if (pick < 10) begin
        // No terminator: the next first beat has to drop this parse.
        txt.delete(txt.size() - 1);
      end else if (pick < 25) begin
        txt.delete();
        repeat ($urandom_range(1, 6)) txt = {txt, 8'($urandom_range(255))};
      end
      send_text(txt);
      // Trailing bytes without the first flag: ignored after a terminator, otherwise
      // they carry on with the unfinished parse.
      repeat ($urandom_range(0, 2)) send_char(8'($urandom_range(255)), 1'b0);
    end

    wait_for_results();
    repeat (DrainCycles) @(negedge clk_i);

    $display("Sent %0d characters in %0d strings; checked %0d results.",
             chars_sent, numbers_sent, parses.results_seen);
    $display("Among them %0d clamped, %0d negative, %0d with the count at its limit.",
             parses.clamped_seen, parses.negative_seen, parses.full_count_seen);
    if (parses.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
